>>> rtl/erlb_pkg.sv
// ----------------------------------------------------------------------------
// erlb_pkg
// Shared types and constants for the expanding ring LED brightness block.
// ----------------------------------------------------------------------------
package erlb_pkg;

   localparam int CFG_W      = 8;
   localparam int FRAME_W    = 16;
   localparam int INDEX_W    = 7;
   localparam int COORD_W    = 8;
   localparam int GAP_W      = 7;
   localparam int GAPSQ_W    = 14;
   localparam int EASE_W     = 22;
   localparam int SQR_W      = 16;
   localparam int DIST_W     = 17;
   localparam int DIVIDEND_W = 24;
   localparam int QUO_W      = 8;
   localparam int RECIP_W    = 23;
   localparam int RECIP_SHIFT = 36;

   localparam logic [1:0] KIND_NONE  = 2'd0;
   localparam logic [1:0] KIND_CLEAR = 2'd1;
   localparam logic [1:0] KIND_OFF   = 2'd2;
   localparam logic [1:0] KIND_HSV   = 2'd3;

   localparam logic [FRAME_W-1:0] FRAME_RING_START = 16'd50;
   localparam logic [FRAME_W-1:0] FRAME_RING_END   = 16'd110;
   // distance to the end of the ease: 100 - (frame - 50)
   localparam logic [7:0] GAP_BASE = 8'd150;
   // ceil(2^36 / 10000), exact for dividends below 2^22
   localparam logic [RECIP_W-1:0] RECIP_MULT = 23'd6871948;

   typedef struct packed {
      logic [CFG_W-1:0] origin_x;
      logic [CFG_W-1:0] origin_y;
      logic [CFG_W-1:0] ring_hue;
      logic [CFG_W-1:0] ring_saturation;
      logic [CFG_W-1:0] peak_value;
      logic [CFG_W-1:0] inner_start_radius;
      logic [CFG_W-1:0] outer_start_radius;
      logic [CFG_W-1:0] final_radius;
   } cfg_type;

   typedef struct packed {
      logic               valid;
      logic               ring;
      logic [INDEX_W-1:0] led_index;
      logic [1:0]         write_kind;
      logic [7:0]         hue;
      logic [7:0]         saturation;
      logic               finished;
      logic               value_en;
   } ctl_type;

endpackage

>>> rtl/expanding_ring_led_brightness.sv
// ----------------------------------------------------------------------------
// expanding_ring_led_brightness
// Startup ring animation: one LED command per LED item, fully pipelined.
// ----------------------------------------------------------------------------
// Input channel: drive frame number, LED index and LED x,y on the req_ ports
// and pulse start; an item is taken on each rising edge with start high and
// busy low. busy is always low, so one item can enter every cycle.
// Result channel: each item yields exactly one command on the rsp_ ports,
// marked by a one-cycle rsp_strobe, in order.
// The pipeline holds eight arithmetic stages (frame decode, squares, ease
// multiply, reciprocal divide by 10000, radii, squared radii, ring test, peak
// scaling) and an eight-stage restoring divider, one quotient bit per stage.
// Throughput is one item per clock.
// There is no receiver back-pressure: results must be taken when strobed.
// Registers are written through the APB-style port at byte address 4*i and
// must only change while no items are in flight.
// Synchronous reset empties the pipeline and loads the register defaults.
// ----------------------------------------------------------------------------
module expanding_ring_led_brightness
   import erlb_pkg::*;
#(
   parameter int NUM_LEDS = 128
)
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [FRAME_W-1:0] req_frame_number,
   input  logic [INDEX_W-1:0] req_led_index,
   input  logic [COORD_W-1:0] req_led_x,
   input  logic [COORD_W-1:0] req_led_y,
   output logic               rsp_strobe,
   output logic [INDEX_W-1:0] rsp_led_target,
   output logic [1:0]         rsp_write_kind,
   output logic [7:0]         rsp_hue_out,
   output logic [7:0]         rsp_saturation_out,
   output logic [7:0]         rsp_value_out,
   output logic               rsp_finished,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [4:0]         paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);

   cfg_type               cfg;
   ctl_type               ring_ctl, div_ctl;
   logic [DIVIDEND_W-1:0] ring_dividend;
   logic [SQR_W-1:0]      ring_divisor;
   logic [QUO_W-1:0]      div_quotient;

   assign busy = 1'b0;

   erlb_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   erlb_ring #(
      .NUM_LEDS (NUM_LEDS)
   ) u_ring (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (start && !busy),
      .frame_number (req_frame_number),
      .led_index    (req_led_index),
      .led_x        (req_led_x),
      .led_y        (req_led_y),
      .cfg          (cfg),
      .out_ctl      (ring_ctl),
      .out_dividend (ring_dividend),
      .out_divisor  (ring_divisor)
   );

   erlb_div u_div (
      .clock        (clock),
      .reset        (reset),
      .in_ctl       (ring_ctl),
      .in_dividend  (ring_dividend),
      .in_divisor   (ring_divisor),
      .out_ctl      (div_ctl),
      .out_quotient (div_quotient)
   );

   assign rsp_strobe         = div_ctl.valid;
   assign rsp_led_target     = div_ctl.led_index;
   assign rsp_write_kind     = div_ctl.write_kind;
   assign rsp_hue_out        = div_ctl.hue;
   assign rsp_saturation_out = div_ctl.saturation;
   assign rsp_value_out      = div_ctl.value_en ? div_quotient : '0;
   assign rsp_finished       = div_ctl.finished;

   // non-hsv commands carry no color
   a_color_only_hsv: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_write_kind != KIND_HSV |->
         rsp_hue_out == '0 && rsp_saturation_out == '0 && rsp_value_out == '0)
      else $error("color fields set on a non-hsv command");

   // finished frames never write
   a_finished_no_write: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_finished |-> rsp_write_kind == KIND_NONE)
      else $error("write command on a finished frame");

   // ramp never exceeds the peak brightness
   a_value_below_peak: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_write_kind == KIND_HSV |-> rsp_value_out <= cfg.peak_value)
      else $error("brightness above peak value");

endmodule

>>> rtl/erlb_csr.sv
// ----------------------------------------------------------------------------
// erlb_csr
// APB-style register file holding the eight ring animation registers.
// ----------------------------------------------------------------------------
module erlb_csr
   import erlb_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [4:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready,
   output cfg_type     cfg
);

   localparam int NUM_REGS = 8;

   localparam logic [2:0] REG_ORIGIN_X     = 3'd0;
   localparam logic [2:0] REG_ORIGIN_Y     = 3'd1;
   localparam logic [2:0] REG_RING_HUE     = 3'd2;
   localparam logic [2:0] REG_RING_SAT     = 3'd3;
   localparam logic [2:0] REG_PEAK_VALUE   = 3'd4;
   localparam logic [2:0] REG_INNER_START  = 3'd5;
   localparam logic [2:0] REG_OUTER_START  = 3'd6;
   localparam logic [2:0] REG_FINAL_RADIUS = 3'd7;

   localparam logic [CFG_W-1:0] RESET_VALS [NUM_REGS] = '{
      8'd192, 8'd50, 8'd145, 8'd235, 8'd150, 8'd0, 8'd40, 8'd250
   };

   logic [CFG_W-1:0] regs_ff [NUM_REGS];
   logic [2:0]       reg_sel;
   logic             wr_en;

   assign reg_sel = paddr[4:2];
   assign wr_en   = psel && penable && pwrite;
   assign pready  = 1'b1;
   assign prdata  = {{(32 - CFG_W){1'b0}}, regs_ff[reg_sel]};

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_REGS; i++) begin
            regs_ff[i] <= RESET_VALS[i];
         end
      end else if (wr_en) begin
         regs_ff[reg_sel] <= pwdata[CFG_W-1:0];
      end
   end

   assign cfg.origin_x           = regs_ff[REG_ORIGIN_X];
   assign cfg.origin_y           = regs_ff[REG_ORIGIN_Y];
   assign cfg.ring_hue           = regs_ff[REG_RING_HUE];
   assign cfg.ring_saturation    = regs_ff[REG_RING_SAT];
   assign cfg.peak_value         = regs_ff[REG_PEAK_VALUE];
   assign cfg.inner_start_radius = regs_ff[REG_INNER_START];
   assign cfg.outer_start_radius = regs_ff[REG_OUTER_START];
   assign cfg.final_radius       = regs_ff[REG_FINAL_RADIUS];

endmodule

>>> rtl/erlb_ring.sv
// ----------------------------------------------------------------------------
// erlb_ring
// Eight-stage front pipeline: frame decode, eased radii, squared distances,
// ring test and the numerator and divisor of the brightness ramp.
// ----------------------------------------------------------------------------
module erlb_ring
   import erlb_pkg::*;
#(
   parameter int NUM_LEDS = 128
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  logic [FRAME_W-1:0]    frame_number,
   input  logic [INDEX_W-1:0]    led_index,
   input  logic [COORD_W-1:0]    led_x,
   input  logic [COORD_W-1:0]    led_y,
   input  cfg_type               cfg,
   output ctl_type               out_ctl,
   output logic [DIVIDEND_W-1:0] out_dividend,
   output logic [SQR_W-1:0]      out_divisor
);

   // ease direction and span; the user must keep them static while items are in flight (not enforced here)
   logic             in_rise, out_rise;
   logic [CFG_W-1:0] in_span, out_span;

   assign in_rise  = cfg.final_radius >= cfg.inner_start_radius;
   assign out_rise = cfg.final_radius >= cfg.outer_start_radius;
   assign in_span  = in_rise ? cfg.final_radius - cfg.inner_start_radius
                             : cfg.inner_start_radius - cfg.final_radius;
   assign out_span = out_rise ? cfg.final_radius - cfg.outer_start_radius
                              : cfg.outer_start_radius - cfg.final_radius;

   // stage 1: frame decode, gap, coordinate distances
   ctl_type            ctl_s1_in, ctl_s1_ff;
   logic [GAP_W-1:0]   gap_s1_ff;
   logic [COORD_W-1:0] dx_s1_ff, dy_s1_ff;

   always_comb begin
      ctl_s1_in            = '0;
      ctl_s1_in.valid      = in_valid;
      ctl_s1_in.led_index  = led_index;
      ctl_s1_in.write_kind = KIND_NONE;
      priority if (frame_number == '0) begin
         ctl_s1_in.write_kind = KIND_CLEAR;
      end else if (frame_number < FRAME_RING_START) begin
         ctl_s1_in.write_kind = KIND_NONE;
      end else if (frame_number < FRAME_RING_END) begin
         ctl_s1_in.ring = 32'(led_index) < NUM_LEDS;
      end else begin
         ctl_s1_in.finished = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      ctl_s1_ff <= reset ? '0 : ctl_s1_in;
      gap_s1_ff <= GAP_W'(GAP_BASE - frame_number[7:0]);
      dx_s1_ff  <= (led_x > cfg.origin_x) ? led_x - cfg.origin_x : cfg.origin_x - led_x;
      dy_s1_ff  <= (led_y > cfg.origin_y) ? led_y - cfg.origin_y : cfg.origin_y - led_y;
   end

   // stage 2: squares of gap and distances
   ctl_type            ctl_s2_ff;
   logic [GAPSQ_W-1:0] gapsq_s2_ff;
   logic [SQR_W-1:0]   dxsq_s2_ff, dysq_s2_ff;

   always_ff @(posedge clock) begin
      ctl_s2_ff   <= reset ? '0 : ctl_s1_ff;
      gapsq_s2_ff <= GAPSQ_W'(gap_s1_ff) * GAPSQ_W'(gap_s1_ff);
      dxsq_s2_ff  <= SQR_W'(dx_s1_ff) * SQR_W'(dx_s1_ff);
      dysq_s2_ff  <= SQR_W'(dy_s1_ff) * SQR_W'(dy_s1_ff);
   end

   // stage 3: ease products, squared distance
   ctl_type           ctl_s3_ff;
   logic [EASE_W-1:0] prod_in_s3_ff, prod_out_s3_ff;
   logic [DIST_W-1:0] dd_s3_ff;

   always_ff @(posedge clock) begin
      ctl_s3_ff      <= reset ? '0 : ctl_s2_ff;
      prod_in_s3_ff  <= EASE_W'(in_span) * EASE_W'(gapsq_s2_ff);
      prod_out_s3_ff <= EASE_W'(out_span) * EASE_W'(gapsq_s2_ff);
      dd_s3_ff       <= DIST_W'(dxsq_s2_ff) + DIST_W'(dysq_s2_ff);
   end

   // stage 4: divide by 10000 through the reciprocal
   ctl_type                       ctl_s4_ff;
   logic [CFG_W-1:0]              q_in_s4_ff, q_out_s4_ff;
   logic [DIST_W-1:0]             dd_s4_ff;
   logic [EASE_W+RECIP_W-1:0]     recip_in_prod, recip_out_prod;

   assign recip_in_prod  = (EASE_W + RECIP_W)'(prod_in_s3_ff) *
                           (EASE_W + RECIP_W)'(RECIP_MULT);
   assign recip_out_prod = (EASE_W + RECIP_W)'(prod_out_s3_ff) *
                           (EASE_W + RECIP_W)'(RECIP_MULT);

   always_ff @(posedge clock) begin
      ctl_s4_ff   <= reset ? '0 : ctl_s3_ff;
      q_in_s4_ff  <= recip_in_prod[RECIP_SHIFT +: CFG_W];
      q_out_s4_ff <= recip_out_prod[RECIP_SHIFT +: CFG_W];
      dd_s4_ff    <= dd_s3_ff;
   end

   // stage 5: eased radii
   ctl_type           ctl_s5_ff;
   logic [CFG_W-1:0]  r_in_s5_ff, r_out_s5_ff;
   logic [DIST_W-1:0] dd_s5_ff;

   always_ff @(posedge clock) begin
      ctl_s5_ff   <= reset ? '0 : ctl_s4_ff;
      r_in_s5_ff  <= in_rise ? cfg.final_radius - q_in_s4_ff
                             : cfg.final_radius + q_in_s4_ff;
      r_out_s5_ff <= out_rise ? cfg.final_radius - q_out_s4_ff
                              : cfg.final_radius + q_out_s4_ff;
      dd_s5_ff    <= dd_s4_ff;
   end

   // stage 6: squared radii
   ctl_type           ctl_s6_ff;
   logic [SQR_W-1:0]  s_in_s6_ff, s_out_s6_ff, s_pk_s6_ff;
   logic [DIST_W-1:0] dd_s6_ff;
   logic [CFG_W:0]    pk_sum;
   logic [CFG_W-1:0]  r_pk;

   assign pk_sum = (CFG_W + 1)'(r_in_s5_ff) + (CFG_W + 1)'(r_out_s5_ff);
   assign r_pk   = pk_sum[CFG_W:1];

   always_ff @(posedge clock) begin
      ctl_s6_ff   <= reset ? '0 : ctl_s5_ff;
      s_in_s6_ff  <= SQR_W'(r_in_s5_ff) * SQR_W'(r_in_s5_ff);
      s_out_s6_ff <= SQR_W'(r_out_s5_ff) * SQR_W'(r_out_s5_ff);
      s_pk_s6_ff  <= SQR_W'(r_pk) * SQR_W'(r_pk);
      dd_s6_ff    <= dd_s5_ff;
   end

   // stage 7: ring test, ramp numerator and divisor
   ctl_type          ctl_s7_in, ctl_s7_ff;
   logic [SQR_W-1:0] num_s7_in, den_s7_in;
   logic [SQR_W-1:0] num_s7_ff, den_s7_ff;
   logic             in_band;

   always_comb begin
      in_band = !(dd_s6_ff > DIST_W'(s_out_s6_ff) || dd_s6_ff < DIST_W'(s_in_s6_ff));
      if (dd_s6_ff > DIST_W'(s_pk_s6_ff)) begin
         num_s7_in = s_out_s6_ff - dd_s6_ff[SQR_W-1:0];
         den_s7_in = s_out_s6_ff - s_pk_s6_ff;
      end else begin
         num_s7_in = dd_s6_ff[SQR_W-1:0] - s_in_s6_ff;
         den_s7_in = s_pk_s6_ff - s_in_s6_ff;
      end
      ctl_s7_in = ctl_s6_ff;
      if (ctl_s6_ff.ring) begin
         if (in_band) begin
            ctl_s7_in.write_kind = KIND_HSV;
            ctl_s7_in.hue        = cfg.ring_hue;
            ctl_s7_in.saturation = cfg.ring_saturation;
            ctl_s7_in.value_en   = den_s7_in != '0;
         end else begin
            ctl_s7_in.write_kind = KIND_OFF;
         end
      end
   end

   always_ff @(posedge clock) begin
      ctl_s7_ff <= reset ? '0 : ctl_s7_in;
      num_s7_ff <= num_s7_in;
      den_s7_ff <= den_s7_in;
   end

   // stage 8: scale numerator by peak brightness
   ctl_type               ctl_s8_ff;
   logic [DIVIDEND_W-1:0] dividend_s8_ff;
   logic [SQR_W-1:0]      den_s8_ff;

   always_ff @(posedge clock) begin
      ctl_s8_ff      <= reset ? '0 : ctl_s7_ff;
      dividend_s8_ff <= DIVIDEND_W'(cfg.peak_value) * DIVIDEND_W'(num_s7_ff);
      den_s8_ff      <= den_s7_ff;
   end

   assign out_ctl      = ctl_s8_ff;
   assign out_dividend = dividend_s8_ff;
   assign out_divisor  = den_s8_ff;

endmodule

>>> rtl/erlb_div.sv
// ----------------------------------------------------------------------------
// erlb_div
// Pipelined restoring divider, one quotient bit per stage. The quotient is
// known to fit in eight bits since the ramp numerator never exceeds the divisor.
// ----------------------------------------------------------------------------
module erlb_div
   import erlb_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  ctl_type               in_ctl,
   input  logic [DIVIDEND_W-1:0] in_dividend,
   input  logic [SQR_W-1:0]      in_divisor,
   output ctl_type               out_ctl,
   output logic [QUO_W-1:0]      out_quotient
);

   ctl_type               ctl_ff   [QUO_W];
   logic [DIVIDEND_W-1:0] rem_ff   [QUO_W];
   logic [SQR_W-1:0]      den_ff   [QUO_W];
   logic [QUO_W-1:0]      quo_ff   [QUO_W];

   ctl_type               ctl_stage [QUO_W];
   logic [DIVIDEND_W-1:0] rem_stage [QUO_W];
   logic [SQR_W-1:0]      den_stage [QUO_W];
   logic [QUO_W-1:0]      quo_stage [QUO_W];

   for (genvar i = 0; i < QUO_W; i++) begin : g_step
      logic [DIVIDEND_W-1:0] trial;
      logic                  take;

      if (i == 0) begin : g_first
         assign ctl_stage[i] = in_ctl;
         assign rem_stage[i] = in_dividend;
         assign den_stage[i] = in_divisor;
         assign quo_stage[i] = '0;
      end else begin : g_next
         assign ctl_stage[i] = ctl_ff[i-1];
         assign rem_stage[i] = rem_ff[i-1];
         assign den_stage[i] = den_ff[i-1];
         assign quo_stage[i] = quo_ff[i-1];
      end

      assign trial = DIVIDEND_W'(den_stage[i]) << (QUO_W - 1 - i);
      assign take  = rem_stage[i] >= trial;

      always_ff @(posedge clock) begin
         ctl_ff[i] <= reset ? '0 : ctl_stage[i];
         den_ff[i] <= den_stage[i];
         rem_ff[i] <= take ? rem_stage[i] - trial : rem_stage[i];
         quo_ff[i] <= quo_stage[i] | (take ? QUO_W'(1) << (QUO_W - 1 - i) : '0);
      end
   end

   assign out_ctl      = ctl_ff[QUO_W-1];
   assign out_quotient = quo_ff[QUO_W-1];

endmodule

>>> sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the expanding ring LED brightness block: a short
// list of directed items at the reset values, then random items over
// several register sets (extremes, empty ring, zero-width ring, falling
// ease, random). Each command is compared with a local model of the ring
// animation, in order, field by field.
// ----------------------------------------------------------------------------
module tb_top
   import erlb_pkg::*;
();

   localparam int NUM_LEDS        = 128;
   localparam int NUM_PHASES      = 10;
   localparam int ITEMS_PER_PHASE = 170;
   localparam int DRAIN_CYCLES    = 20;
   localparam int STALL_LIMIT     = 1000;
   localparam int EASE_SPAN       = 100;
   localparam int EASE_DEN        = EASE_SPAN * EASE_SPAN;
   localparam int NUM_DIRECTED    = 18;

   typedef enum logic [2:0] {
      CSR_ORIGIN_X,
      CSR_ORIGIN_Y,
      CSR_RING_HUE,
      CSR_RING_SAT,
      CSR_PEAK_VALUE,
      CSR_INNER_START,
      CSR_OUTER_START,
      CSR_FINAL_RADIUS
   } csr_reg_type;

   typedef struct packed {
      logic [INDEX_W-1:0] target;
      logic [1:0]         kind;
      logic [7:0]         hue;
      logic [7:0]         sat;
      logic [7:0]         val;
      logic               fin;
   } led_cmd_type;

   typedef struct packed {
      logic [FRAME_W-1:0] frame;
      logic [INDEX_W-1:0] index;
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic               typed;
      led_cmd_type        cmd;
   } stim_row_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic [FRAME_W-1:0] req_frame_number = '0;
   logic [INDEX_W-1:0] req_led_index = '0;
   logic [COORD_W-1:0] req_led_x = '0;
   logic [COORD_W-1:0] req_led_y = '0;
   logic               rsp_strobe;
   logic [INDEX_W-1:0] rsp_led_target;
   logic [1:0]         rsp_write_kind;
   logic [7:0]         rsp_hue_out;
   logic [7:0]         rsp_saturation_out;
   logic [7:0]         rsp_value_out;
   logic               rsp_finished;
   logic               psel = 1'b0;
   logic               penable = 1'b0;
   logic               pwrite = 1'b0;
   logic [4:0]         paddr = '0;
   logic [31:0]        pwdata = '0;
   logic [31:0]        prdata;
   logic               pready;

   logic [7:0]  ring_cfg [8] = '{8'd192, 8'd50, 8'd145, 8'd235, 8'd150, 8'd0, 8'd40, 8'd250};
   led_cmd_type pending_cmds [$];
   int          mismatches = 0;
   int          quiet_edges = 0;

   // fixed register sets: extremes, zero-width ring, empty ring, falling ease
   logic [7:0] phase_set [5][8] = '{
      '{8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0},
      '{8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255},
      '{8'd0,   8'd0,   8'd77,  8'd180, 8'd255, 8'd10,  8'd10,  8'd10},
      '{8'd100, 8'd140, 8'd12,  8'd34,  8'd200, 8'd200, 8'd20,  8'd100},
      '{8'd128, 8'd128, 8'd90,  8'd60,  8'd255, 8'd250, 8'd255, 8'd30}
   };

   stim_row_type directed_rows [NUM_DIRECTED] = '{
      '{16'd0,     7'd0,   8'd0,   8'd0,   1'b1, '{7'd0,   KIND_CLEAR, 8'd0, 8'd0, 8'd0, 1'b0}},
      '{16'd0,     7'd127, 8'd255, 8'd255, 1'b1, '{7'd127, KIND_CLEAR, 8'd0, 8'd0, 8'd0, 1'b0}},
      '{16'd1,     7'd64,  8'd17,  8'd200, 1'b1, '{7'd64,  KIND_NONE,  8'd0, 8'd0, 8'd0, 1'b0}},
      '{16'd49,    7'd127, 8'd192, 8'd50,  1'b1, '{7'd127, KIND_NONE,  8'd0, 8'd0, 8'd0, 1'b0}},
      '{16'd110,   7'd3,   8'd192, 8'd50,  1'b1, '{7'd3,   KIND_NONE,  8'd0, 8'd0, 8'd0, 1'b1}},
      '{16'd65535, 7'd127, 8'd255, 8'd255, 1'b1, '{7'd127, KIND_NONE,  8'd0, 8'd0, 8'd0, 1'b1}},
      '{16'd32768, 7'd85,  8'hAA,  8'h55,  1'b1, '{7'd85,  KIND_NONE,  8'd0, 8'd0, 8'd0, 1'b1}},
      '{16'd50,    7'd10,  8'd192, 8'd50,  1'b0, '0},
      '{16'd50,    7'd11,  8'd212, 8'd50,  1'b0, '0},
      '{16'd50,    7'd12,  8'd232, 8'd50,  1'b0, '0},
      '{16'd50,    7'd13,  8'd233, 8'd50,  1'b0, '0},
      '{16'd50,    7'd14,  8'd0,   8'd0,   1'b0, '0},
      '{16'd109,   7'd15,  8'd255, 8'd255, 1'b0, '0},
      '{16'd109,   7'd16,  8'd0,   8'd255, 1'b0, '0},
      '{16'd109,   7'd17,  8'd192, 8'd50,  1'b0, '0},
      '{16'd80,    7'd18,  8'd100, 8'd150, 1'b0, '0},
      '{16'd108,   7'd19,  8'd192, 8'd0,   1'b0, '0},
      '{16'd60,    7'd20,  8'd150, 8'd80,  1'b0, '0}
   };

   expanding_ring_led_brightness #(.NUM_LEDS(NUM_LEDS)) uut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_frame_number   (req_frame_number),
      .req_led_index      (req_led_index),
      .req_led_x          (req_led_x),
      .req_led_y          (req_led_y),
      .rsp_strobe         (rsp_strobe),
      .rsp_led_target     (rsp_led_target),
      .rsp_write_kind     (rsp_write_kind),
      .rsp_hue_out        (rsp_hue_out),
      .rsp_saturation_out (rsp_saturation_out),
      .rsp_value_out      (rsp_value_out),
      .rsp_finished       (rsp_finished),
      .psel               (psel),
      .penable            (penable),
      .pwrite             (pwrite),
      .paddr              (paddr),
      .pwdata             (pwdata),
      .prdata             (prdata),
      .pready             (pready)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic int unsigned ease_edge(input logic [7:0] from, input logic [7:0] to,
                                             input logic [FRAME_W-1:0] frame);
      int unsigned s, f, gap, sq;
      s = 32'(from);
      f = 32'(to);
      gap = EASE_SPAN - (int'(frame) - int'(FRAME_RING_START));
      sq = gap * gap;
      if (f >= s) begin
         return f - (f - s) * sq / EASE_DEN;
      end
      return f + (s - f) * sq / EASE_DEN;
   endfunction

   function automatic led_cmd_type led_command(input logic [FRAME_W-1:0] frame,
                                               input logic [INDEX_W-1:0] idx,
                                               input logic [COORD_W-1:0] x,
                                               input logic [COORD_W-1:0] y);
      led_cmd_type c;
      int unsigned r_in, r_out, r_pk, s_in, s_out, s_pk, dx, dy, dd, num, den;
      c = '0;
      c.target = idx;
      if (frame == 0) begin
         c.kind = KIND_CLEAR;
      end else if (frame < FRAME_RING_START) begin
         c.kind = KIND_NONE;
      end else if (frame < FRAME_RING_END) begin
         if (int'(idx) < NUM_LEDS) begin
            r_in  = ease_edge(ring_cfg[CSR_INNER_START], ring_cfg[CSR_FINAL_RADIUS], frame);
            r_out = ease_edge(ring_cfg[CSR_OUTER_START], ring_cfg[CSR_FINAL_RADIUS], frame);
            r_pk  = (r_in + r_out) >> 1;
            s_in  = r_in * r_in;
            s_out = r_out * r_out;
            s_pk  = r_pk * r_pk;
            dx = 32'((x > ring_cfg[CSR_ORIGIN_X]) ? x - ring_cfg[CSR_ORIGIN_X]
                                                  : ring_cfg[CSR_ORIGIN_X] - x);
            dy = 32'((y > ring_cfg[CSR_ORIGIN_Y]) ? y - ring_cfg[CSR_ORIGIN_Y]
                                                  : ring_cfg[CSR_ORIGIN_Y] - y);
            dd = dx * dx + dy * dy;
            if (dd > s_out || dd < s_in) begin
               c.kind = KIND_OFF;
            end else begin
               if (dd > s_pk) begin
                  num = s_out - dd;
                  den = s_out - s_pk;
               end else begin
                  num = dd - s_in;
                  den = s_pk - s_in;
               end
               c.kind = KIND_HSV;
               c.hue  = ring_cfg[CSR_RING_HUE];
               c.sat  = ring_cfg[CSR_RING_SAT];
               c.val  = (den == 0) ? 8'd0 : 8'(32'(ring_cfg[CSR_PEAK_VALUE]) * num / den);
            end
         end
      end else begin
         c.fin = 1'b1;
      end
      return c;
   endfunction

   // coordinate at offset d from centre c, on a random side that stays in range
   function automatic logic [7:0] coord_near(input logic [7:0] c, input int unsigned d);
      int p;
      p = $urandom_range(0, 1) ? int'(c) + int'(d) : int'(c) - int'(d);
      if (p < 0 || p > 255) begin
         p = (p < 0) ? int'(c) + int'(d) : int'(c) - int'(d);
      end
      if (p < 0) p = 0;
      if (p > 255) p = 255;
      return 8'(p);
   endfunction

   task automatic drive_item(input logic [FRAME_W-1:0] f, input logic [INDEX_W-1:0] i,
                             input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                             input led_cmd_type want);
      start <= 1'b1;
      req_frame_number <= f;
      req_led_index <= i;
      req_led_x <= x;
      req_led_y <= y;
      do @(posedge clock); while (busy !== 1'b0);
      pending_cmds.push_back(want);
   endtask

   task automatic hold_off(input int n);
      start <= 1'b0;
      req_frame_number <= 16'($urandom);
      req_led_index <= 7'($urandom);
      req_led_x <= 8'($urandom);
      req_led_y <= 8'($urandom);
      repeat (n) @(posedge clock);
   endtask

   task automatic csr_write(input csr_reg_type r, input logic [7:0] v);
      logic [31:0] noise;
      noise = $urandom;
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= 5'(int'(r) * 4);
      pwdata <= {noise[31:8], v};
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      psel <= 1'b0;
      penable <= 1'b0;
      ring_cfg[r] = v;
      @(posedge clock);
   endtask

   task automatic check_field(input string name, input int unsigned want, input int unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      led_cmd_type want;
      if (!reset && rsp_strobe === 1'b1) begin
         if (pending_cmds.size() == 0) begin
            $display("%0t: unexpected item, expected none, actual target %0d kind %0d",
                     $time, rsp_led_target, rsp_write_kind);
            mismatches++;
         end else begin
            want = pending_cmds.pop_front();
            check_field("led_target", 32'(want.target), 32'(rsp_led_target));
            check_field("write_kind", 32'(want.kind), 32'(rsp_write_kind));
            check_field("hue_out", 32'(want.hue), 32'(rsp_hue_out));
            check_field("saturation_out", 32'(want.sat), 32'(rsp_saturation_out));
            check_field("value_out", 32'(want.val), 32'(rsp_value_out));
            check_field("finished", 32'(want.fin), 32'(rsp_finished));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe || (psel && penable && pwrite && pready)) begin
         quiet_edges <= 0;
      end else if (quiet_edges >= STALL_LIMIT) begin
         $display("expanding_ring_led_brightness regression: fail");
         $finish;
      end else begin
         quiet_edges <= quiet_edges + 1;
      end
   end

   initial begin
      int              ph, n, r, idle_pct, pick;
      int unsigned     ri, ro, rr, dx, dy, rem;
      logic [FRAME_W-1:0] frame;
      logic [INDEX_W-1:0] idx;
      logic [COORD_W-1:0] x, y;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      for (ph = 0; ph < NUM_PHASES; ph++) begin
         if (ph > 0) begin
            hold_off(0);
            while (pending_cmds.size() != 0) @(posedge clock);
            repeat (DRAIN_CYCLES) @(posedge clock);
            for (r = 0; r < 8; r++) begin
               csr_write(csr_reg_type'(r), (ph <= 5) ? phase_set[ph-1][r] : 8'($urandom));
            end
         end
         idle_pct = (ph == NUM_PHASES - 1) ? 0 : $urandom_range(0, 30);
         n = 0;
         if (ph == 0) begin
            for (n = 0; n < NUM_DIRECTED; n++) begin
               drive_item(directed_rows[n].frame, directed_rows[n].index, directed_rows[n].x,
                          directed_rows[n].y,
                          directed_rows[n].typed ? directed_rows[n].cmd
                             : led_command(directed_rows[n].frame, directed_rows[n].index,
                                           directed_rows[n].x, directed_rows[n].y));
            end
         end
         for (; n < ITEMS_PER_PHASE; n++) begin
            pick = $urandom_range(0, 99);
            idx = 7'($urandom);
            x = 8'($urandom);
            y = 8'($urandom);
            if (pick < 4) begin
               frame = '0;
            end else if (pick < 8) begin
               frame = 16'($urandom_range(1, 49));
            end else if (pick < 11) begin
               frame = 16'($urandom_range(110, 65535));
            end else if (pick < 14) begin
               frame = 16'($urandom);
            end else begin
               frame = 16'($urandom_range(50, 109));
               if (pick < 60) begin
                  // aim at the ring band of this frame
                  ri = ease_edge(ring_cfg[CSR_INNER_START], ring_cfg[CSR_FINAL_RADIUS], frame);
                  ro = ease_edge(ring_cfg[CSR_OUTER_START], ring_cfg[CSR_FINAL_RADIUS], frame);
                  rr = $urandom_range(ri, ro);
                  dx = $urandom_range(0, rr);
                  rem = rr * rr - dx * dx;
                  dy = 0;
                  while ((dy + 1) * (dy + 1) <= rem) dy++;
                  x = coord_near(ring_cfg[CSR_ORIGIN_X], dx);
                  y = coord_near(ring_cfg[CSR_ORIGIN_Y], dy);
               end
            end
            if ($urandom_range(0, 99) < idle_pct) begin
               hold_off($urandom_range(1, 13));
            end
            drive_item(frame, idx, x, y, led_command(frame, idx, x, y));
         end
      end
      hold_off(0);
      while (pending_cmds.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("expanding_ring_led_brightness regression: pass");
      end else begin
         $display("expanding_ring_led_brightness regression: fail");
      end
      $finish;
   end

endmodule
